// ===== hw/rtl/pbd_pkg.sv =====
`timescale 1ns / 1ps

package pbd_pkg;

  // Sample path widths
  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 32;
  localparam int TIME_W   = 32;
  localparam int BPM_W    = 8;

  // FIR delay line
  localparam int LINE_DEPTH = 32;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int NTAP       = 12;              // distinct coefficients (23-tap symmetric)
  localparam int TAP_IW     = $clog2(NTAP);
  localparam int TAP_W      = 13;
  localparam int PAIR_W     = SAMPLE_W + 1;
  localparam int PROD_W     = PAIR_W + TAP_W + 1;
  localparam int FIR_W      = 32;

  // Shared divider
  localparam int DIV_W   = 16;
  localparam int DIV_CW  = $clog2(DIV_W);
  localparam logic [DIV_W-1:0] MS_PER_MINUTE = 16'd60000;

  // Configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int REG_W  = 16;

  localparam logic [1:0] REG_AMP_FLOOR   = 2'd0;
  localparam logic [1:0] REG_AMP_CEILING = 2'd1;
  localparam logic [1:0] REG_INT_MIN     = 2'd2;
  localparam logic [1:0] REG_INT_MAX     = 2'd3;

  localparam logic [REG_W-1:0] RST_AMP_FLOOR   = 16'd10;
  localparam logic [REG_W-1:0] RST_AMP_CEILING = 16'd7000;
  localparam logic [REG_W-1:0] RST_INT_MIN     = 16'd300;
  localparam logic [REG_W-1:0] RST_INT_MAX     = 16'd3000;

  typedef struct packed {
    logic [REG_W-1:0] amp_floor;
    logic [REG_W-1:0] amp_ceiling;
    logic [REG_W-1:0] int_min;
    logic [REG_W-1:0] int_max;
  } pbd_cfg_t;

  typedef struct packed {
    logic                start;
    logic [DIV_W-1:0]    dividend;
    logic [DIV_W-1:0]    divisor;
  } pbd_div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_W-1:0]    quotient;
  } pbd_div_rsp_t;

  typedef struct packed {
    logic                we;
    logic [LINE_AW-1:0]  addr;
    logic [SAMPLE_W-1:0] data;
  } pbd_line_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DC,
    ST_WR,
    ST_TAP,
    ST_POST,
    ST_GATE,
    ST_BPM_GO,
    ST_BPM_WAIT,
    ST_HIST,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_DONE
  } pbd_state_t;

  // Half of the symmetric low-pass kernel, outermost tap first, centre last
  function automatic logic [TAP_W-1:0] fir_tap(input logic [TAP_IW-1:0] idx);
    logic [TAP_W-1:0] c;
    unique case (idx)
      4'd0:    c = 13'd172;
      4'd1:    c = 13'd321;
      4'd2:    c = 13'd579;
      4'd3:    c = 13'd927;
      4'd4:    c = 13'd1360;
      4'd5:    c = 13'd1858;
      4'd6:    c = 13'd2390;
      4'd7:    c = 13'd2916;
      4'd8:    c = 13'd3391;
      4'd9:    c = 13'd3768;
      4'd10:   c = 13'd4017;
      4'd11:   c = 13'd4096;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/pbd_if.sv =====
`timescale 1ns / 1ps

interface pbd_in_if;
  logic        valid;
  logic        ready;
  logic [17:0] ir_sample;
  logic [31:0] now_ms;

  modport source (output valid, output ir_sample, output now_ms, input ready);
  modport sink   (input valid, input ir_sample, input now_ms, output ready);
endinterface

interface pbd_out_if;
  logic               valid;
  logic               ready;
  logic               beat;
  logic               rate_accepted;
  logic [7:0]         beat_average;
  logic signed [15:0] filtered_value;

  modport source (output valid, output beat, output rate_accepted, output beat_average,
                  output filtered_value, input ready);
  modport sink   (input valid, input beat, input rate_accepted, input beat_average,
                  input filtered_value, output ready);
endinterface

// ===== hw/rtl/pbd_regs.sv =====
`timescale 1ns / 1ps

module pbd_regs import pbd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output pbd_cfg_t          cfg
);

  logic [REG_W-1:0] floor_r, ceil_r, imin_r, imax_r;
  logic             wr_en;
  logic [1:0]       reg_idx;
  logic [REG_W-1:0] rd_val;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= RST_AMP_FLOOR;
      ceil_r  <= RST_AMP_CEILING;
      imin_r  <= RST_INT_MIN;
      imax_r  <= RST_INT_MAX;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_AMP_FLOOR:   floor_r <= pwdata[REG_W-1:0];
        REG_AMP_CEILING: ceil_r  <= pwdata[REG_W-1:0];
        REG_INT_MIN:     imin_r  <= pwdata[REG_W-1:0];
        REG_INT_MAX:     imax_r  <= pwdata[REG_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_AMP_FLOOR:   rd_val = floor_r;
      REG_AMP_CEILING: rd_val = ceil_r;
      REG_INT_MIN:     rd_val = imin_r;
      REG_INT_MAX:     rd_val = imax_r;
      default:         rd_val = '0;
    endcase
  end

  assign prdata = {{(CFG_DW-REG_W){1'b0}}, rd_val};

  assign cfg.amp_floor   = floor_r;
  assign cfg.amp_ceiling = ceil_r;
  assign cfg.int_min     = imin_r;
  assign cfg.int_max     = imax_r;

endmodule

// ===== hw/rtl/pbd_line.sv =====
`timescale 1ns / 1ps

module pbd_line import pbd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  pbd_line_wr_t        wr,
  input  logic [LINE_AW-1:0]  rd_addr_a,
  input  logic [LINE_AW-1:0]  rd_addr_b,
  output logic [SAMPLE_W-1:0] rd_data_a,
  output logic [SAMPLE_W-1:0] rd_data_b
);

  logic [SAMPLE_W-1:0] mem [LINE_DEPTH];
  logic [LINE_DEPTH-1:0] vld_r;
  logic [SAMPLE_W-1:0] mem_a_r, mem_b_r;
  logic                vld_a_r, vld_b_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    mem_a_r <= mem[rd_addr_a];
    mem_b_r <= mem[rd_addr_b];
  end

  // Entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (wr.we) begin
        vld_r[wr.addr] <= 1'b1;
      end
      vld_a_r <= vld_r[rd_addr_a];
      vld_b_r <= vld_r[rd_addr_b];
    end
  end

  assign rd_data_a = vld_a_r ? mem_a_r : '0;
  assign rd_data_b = vld_b_r ? mem_b_r : '0;

endmodule

// ===== hw/rtl/pbd_div.sv =====
`timescale 1ns / 1ps

module pbd_div import pbd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  pbd_div_req_t req,
  output pbd_div_rsp_t rsp
);

  logic [DIV_W-1:0]  rem_r, quo_r, dvs_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DIV_W:0]    rem_sh, trial;
  logic              ge;

  // Restoring division, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign trial  = rem_sh - {1'b0, dvs_r};
  assign ge     = !trial[DIV_W];

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? trial[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_W-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== hw/rtl/pulse_beat_detector_unit.sv =====
`timescale 1ns / 1ps

// Optical pulse beat detector.
// in_chan carries one infrared sample (low 16 bits used) and a millisecond
// timestamp per beat; out_chan returns one result per sample: beat flag,
// rate-accepted flag, held average bpm and the low-pass filtered value.
// The APB-style port holds the amplitude and interval gates (registers at
// byte addresses 0, 4, 8, 12); pready is tied high, writes land on the
// access cycle.
// Each sample is worked by a small sequencer around shared units: DC tracker
// update, delay line write, 12 tap reads through the two-port delay line into
// one multiplier, extrema and gating, then, when both gates pass, the shared
// divider for 60000/interval and again for the history average.
// The next sample is taken in the cycle after the result has moved into the
// output register, so no new sample is taken while one is being worked.
// Reset (synchronous, rst_n low) clears the DC tracker, delay line (valid
// bits), extrema, beat time, rate history and average, and restores the
// register defaults. If the receiver stalls, the result waits in the output
// register; one further sample may be taken and then waits until it drains.

module pulse_beat_detector_unit import pbd_pkg::*; #(
  parameter int RATE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  pbd_in_if.sink            in_chan,
  pbd_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int PTR_W = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
  localparam int SUM_W = BPM_W + PTR_W;
  localparam logic [TAP_IW:0] TAP_LAST = (TAP_IW+1)'(NTAP + 2);

  pbd_cfg_t     cfg;
  pbd_div_req_t div_req;
  pbd_div_rsp_t div_rsp;
  pbd_line_wr_t line_wr;

  pbd_state_t state_r, state_nxt;

  // ---- control decode -------------------------------------------------
  logic in_acc, out_load, rd_issue, div_start, div_for_bpm, line_we;

  // ---- sample path registers -------------------------------------------
  logic [SAMPLE_W-1:0]  x_r;
  logic [TIME_W-1:0]    now_r;
  logic [ACC_W-1:0]     dc_r, dc_nxt;
  logic signed [ACC_W+1:0] dc_diff, dc_step;
  logic [SAMPLE_W-1:0]  din;
  logic [LINE_AW-1:0]   wp_r;
  logic [TAP_IW:0]      cnt_r, cnt_nxt;
  logic [LINE_AW-1:0]   rd_addr_a, rd_addr_b;
  logic [SAMPLE_W-1:0]  rd_data_a, rd_data_b;

  // tap pipeline: read -> pair -> product -> accumulate
  logic                     rv1_r, rv2_r, rv3_r;
  logic [TAP_IW-1:0]        idx1_r, idx2_r;
  logic signed [PAIR_W-1:0] pair_nxt, pair_r;
  logic signed [TAP_W:0]    tap_s;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic signed [FIR_W-1:0]  fir_r;

  // ---- beat logic -------------------------------------------------------
  logic signed [SAMPLE_W-1:0] cur, cur_r, fprev_r, smax_r, smin_r;
  logic                       cross_r;
  logic signed [SAMPLE_W:0]   amp;
  logic [TIME_W-1:0]          last_r, delta;
  logic [DIV_W-1:0]           delta_r;
  logic                       amp_ok, int_ok;
  logic                       beat_f_r, rate_f_r;

  // ---- rate history -----------------------------------------------------
  logic [BPM_W-1:0] hist_r [RATE_DEPTH];
  logic [PTR_W-1:0] ptr_r;
  logic [SUM_W-1:0] sum_r;
  logic [BPM_W-1:0] avg_r, bpm;

  // ---- output register --------------------------------------------------
  logic                       out_valid_r, out_beat_r, out_rate_r;
  logic [BPM_W-1:0]           out_avg_r;
  logic signed [SAMPLE_W-1:0] out_filt_r;

  pbd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pbd_line u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (line_wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  pbd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---- sequencer: next state --------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_chan.valid) state_nxt = ST_DC;
      ST_DC:       state_nxt = ST_WR;
      ST_WR:       state_nxt = ST_TAP;
      ST_TAP:      if (cnt_r == TAP_LAST) state_nxt = ST_POST;
      ST_POST:     state_nxt = ST_GATE;
      ST_GATE:     state_nxt = (amp_ok && int_ok) ? ST_BPM_GO : ST_DONE;
      ST_BPM_GO:   state_nxt = ST_BPM_WAIT;
      ST_BPM_WAIT: if (div_rsp.done) state_nxt = ST_HIST;
      ST_HIST:     state_nxt = ST_AVG_GO;
      ST_AVG_GO:   state_nxt = ST_AVG_WAIT;
      ST_AVG_WAIT: if (div_rsp.done) state_nxt = ST_DONE;
      ST_DONE:     if (!out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ---- sequencer: outputs -----------------------------------------------
  always_comb begin
    in_chan.ready = 1'b0;
    rd_issue      = 1'b0;
    div_start     = 1'b0;
    div_for_bpm   = 1'b0;
    out_load      = 1'b0;
    line_we       = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_chan.ready = 1'b1;
      ST_WR:     line_we = 1'b1;
      ST_TAP:    rd_issue = (cnt_r < (TAP_IW+1)'(NTAP));
      ST_BPM_GO: begin
        div_start   = 1'b1;
        div_for_bpm = 1'b1;
      end
      ST_AVG_GO: div_start = 1'b1;
      ST_DONE:   out_load = !out_valid_r || out_chan.ready;
      default:   ;
    endcase
  end

  assign in_acc = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign cnt_nxt = (state_r == ST_TAP) ? cnt_r + 1'b1 : '0;

  // ---- DC tracker: acc += floor((x<<15 - acc) / 16) ---------------------
  assign dc_diff = $signed({3'b000, x_r, 15'd0}) - $signed({2'b00, dc_r});
  assign dc_step = dc_diff >>> 4;
  assign dc_nxt  = dc_r + dc_step[ACC_W-1:0];

  // baseline is bits 30..15 of the tracker
  assign din = x_r - dc_r[30:15];

  assign line_wr.we   = line_we;
  assign line_wr.addr = wp_r;
  assign line_wr.data = din;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r   <= in_chan.ir_sample[SAMPLE_W-1:0];
      now_r <= in_chan.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r <= '0;
      wp_r <= '0;
    end else begin
      if (state_r == ST_DC) begin
        dc_r <= dc_nxt;
      end
      if (state_r == ST_TAP && cnt_r == TAP_LAST) begin
        wp_r <= wp_r + 1'b1;
      end
    end
  end

  // ---- FIR taps ---------------------------------------------------------
  // Step i pairs the sample i back with the one 22-i back; the centre tap
  // (last step) has no partner.
  assign rd_addr_a = wp_r - LINE_AW'(cnt_r);
  assign rd_addr_b = wp_r - LINE_AW'(2 * (NTAP - 1)) + LINE_AW'(cnt_r);

  assign pair_nxt = $signed({rd_data_a[SAMPLE_W-1], rd_data_a})
                  + ((idx1_r == TAP_IW'(NTAP - 1)) ? $signed({PAIR_W{1'b0}})
                                                    : $signed({rd_data_b[SAMPLE_W-1],
                                                               rd_data_b}));
  assign tap_s    = $signed({1'b0, fir_tap(idx2_r)});
  assign prod_nxt = PROD_W'(pair_r) * PROD_W'(tap_s);

  always_ff @(posedge clk) begin
    idx1_r <= cnt_r[TAP_IW-1:0];
    idx2_r <= idx1_r;
    pair_r <= pair_nxt;
    prod_r <= prod_nxt;
    if (state_r == ST_WR) begin
      fir_r <= '0;
    end else if (rv3_r) begin
      fir_r <= fir_r + FIR_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv1_r <= 1'b0;
      rv2_r <= 1'b0;
      rv3_r <= 1'b0;
    end else begin
      rv1_r <= rd_issue;
      rv2_r <= rv1_r;
      rv3_r <= rv2_r;
    end
  end

  // ---- extrema, zero crossing and gates ---------------------------------
  assign cur    = fir_r[30:15];
  assign amp    = $signed({smax_r[SAMPLE_W-1], smax_r}) - $signed({smin_r[SAMPLE_W-1], smin_r});
  assign delta  = now_r - last_r;
  // extrema bracket the current value, so the swing is never negative
  assign amp_ok = cross_r
               && ($unsigned(amp) > {1'b0, cfg.amp_floor})
               && ($unsigned(amp) < {1'b0, cfg.amp_ceiling});
  assign int_ok = (delta > TIME_W'(cfg.int_min)) && (delta < TIME_W'(cfg.int_max));

  always_ff @(posedge clk) begin
    if (state_r == ST_POST) begin
      cur_r   <= cur;
      cross_r <= fprev_r[SAMPLE_W-1] && !cur[SAMPLE_W-1];
    end
    if (state_r == ST_GATE) begin
      beat_f_r <= amp_ok;
      rate_f_r <= amp_ok && int_ok;
      delta_r  <= delta[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fprev_r <= '0;
      smax_r  <= 16'sh8000;
      smin_r  <= 16'sh7FFF;
      last_r  <= '0;
    end else begin
      if (state_r == ST_POST) begin
        fprev_r <= cur;
        if (cur > smax_r) smax_r <= cur;
        if (cur < smin_r) smin_r <= cur;
      end
      if (state_r == ST_GATE) begin
        // extrema restart after every rising crossing, gated or not
        if (cross_r) begin
          smax_r <= 16'sh8000;
          smin_r <= 16'sh7FFF;
        end
        if (amp_ok) last_r <= now_r;
      end
    end
  end

  // ---- shared divider: 60000 / interval, then history sum / depth -------
  assign div_req.start    = div_start;
  assign div_req.dividend = div_for_bpm ? MS_PER_MINUTE : DIV_W'(sum_r);
  assign div_req.divisor  = div_for_bpm ? delta_r : DIV_W'(RATE_DEPTH);

  // saturate rates above 255 bpm
  assign bpm = (|div_rsp.quotient[DIV_W-1:BPM_W]) ? {BPM_W{1'b1}}
                                                 : div_rsp.quotient[BPM_W-1:0];

  // running sum stands in for re-adding the whole history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RATE_DEPTH; i++) hist_r[i] <= '0;
      ptr_r <= '0;
      sum_r <= '0;
      avg_r <= '0;
    end else begin
      if (state_r == ST_HIST) begin
        hist_r[ptr_r] <= bpm;
        sum_r <= sum_r - SUM_W'(hist_r[ptr_r]) + SUM_W'(bpm);
        ptr_r <= (ptr_r == PTR_W'(RATE_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
      end
      if (state_r == ST_AVG_WAIT && div_rsp.done) begin
        avg_r <= div_rsp.quotient[BPM_W-1:0];
      end
    end
  end

  // ---- output register --------------------------------------------------
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_beat_r <= beat_f_r;
      out_rate_r <= rate_f_r;
      out_avg_r  <= avg_r;
      out_filt_r <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.beat           = out_beat_r;
  assign out_chan.rate_accepted  = out_rate_r;
  assign out_chan.beat_average   = out_avg_r;
  assign out_chan.filtered_value = out_filt_r;

endmodule

// ===== tb/pulse_beat_detector_unit_tb.sv =====
`timescale 1ns / 1ps

module pulse_beat_detector_unit_tb;
  import pbd_pkg::*;

  localparam int HIST_DEPTH   = 4;     // bpm history ring, matches the DUT parameter
  localparam int STALL_LIMIT  = 4000;  // cycles without any beat on either channel
  localparam int DRAIN_CYCLES = 64;    // final wait, longer than the worst sample latency

  // One output beat of the block
  typedef struct packed {
    logic               beat;
    logic               rate_acc;
    logic [7:0]         avg;
    logic signed [15:0] filt;
  } reading_t;

  // One row of the directed table; res only counts where typed is set
  typedef struct packed {
    logic [17:0] ir;
    logic [31:0] ms;
    logic        typed;
    reading_t    res;
  } probe_row_t;

  localparam reading_t NO_READING = '0;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  pbd_in_if  in_bus ();
  pbd_out_if out_bus ();

  pulse_beat_detector_unit #(.RATE_DEPTH(HIST_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 10 ns clock, low half then high half
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the detector
  // ---------------------------------------------------------------------------
  logic [31:0]        trk_acc;           // DC tracker, Q15 baseline in bits 30..15
  logic signed [15:0] lp_line [32];      // FIR delay line
  int                 lp_wp;
  logic signed [15:0] lp_prev;           // filtered value of the previous sample
  logic signed [15:0] swing_hi;
  logic signed [15:0] swing_lo;
  logic [31:0]        beat_ms;           // time of the last gated heartbeat
  logic [7:0]         bpm_ring [HIST_DEPTH];
  int                 ring_wp;
  logic [7:0]         bpm_avg;
  logic [15:0]        gate_amp_floor;
  logic [15:0]        gate_amp_ceiling;
  logic [15:0]        gate_int_min;
  logic [15:0]        gate_int_max;

  reading_t    awaited_readings [$];
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  int          src_idle_pct   = 26;
  int          sink_idle_pct  = 83;
  int          items_sent     = 0;
  int          items_quota    = 0;
  logic [31:0] stream_ms;

  // Half of the symmetric low-pass kernel, outermost first, centre tap last
  function automatic int lp_coef(input int idx);
    case (idx)
      0:       return 172;
      1:       return 321;
      2:       return 579;
      3:       return 927;
      4:       return 1360;
      5:       return 1858;
      6:       return 2390;
      7:       return 2916;
      8:       return 3391;
      9:       return 3768;
      10:      return 4017;
      default: return 4096;
    endcase
  endfunction

  task automatic clear_model();
    trk_acc  = '0;
    foreach (lp_line[i]) lp_line[i] = '0;
    lp_wp    = 0;
    lp_prev  = '0;
    swing_hi = 16'sh8000;
    swing_lo = 16'sh7FFF;
    beat_ms  = '0;
    foreach (bpm_ring[i]) bpm_ring[i] = '0;
    ring_wp  = 0;
    bpm_avg  = '0;
    gate_amp_floor   = RST_AMP_FLOOR;
    gate_amp_ceiling = RST_AMP_CEILING;
    gate_int_min     = RST_INT_MIN;
    gate_int_max     = RST_INT_MAX;
  endtask

  // Advances the predictor by one sample and returns the reading it should give
  function automatic reading_t predict_reading(input logic [17:0] ir, input logic [31:0] ms);
    logic [15:0]        x;
    logic signed [63:0] diff;
    logic signed [63:0] nudge;
    logic signed [15:0] ac;
    logic signed [15:0] lp_out;
    logic signed [15:0] prior;
    int                 acc_z;
    int                 p;
    int                 i;
    int                 swing;
    logic [31:0]        gap_ms;
    int unsigned        bpm;
    int unsigned        ring_sum;
    reading_t           r;
    x = ir[15:0];                         // top two ADC bits are dropped

    // DC tracker: step of a sixteenth towards the sample, floored, signed
    diff    = $signed({33'd0, x, 15'd0}) - $signed({32'd0, trk_acc});
    nudge   = diff >>> 4;
    trk_acc = trk_acc + nudge[31:0];
    ac      = x - trk_acc[30:15];

    // 23-tap symmetric FIR, pairs folded around the centre tap
    p          = lp_wp;
    lp_line[p] = ac;
    acc_z      = lp_coef(11) * int'(lp_line[(p - 11) & 31]);
    for (i = 0; i < 11; i++)
      acc_z += lp_coef(i) * (int'(lp_line[(p - i) & 31]) + int'(lp_line[(p - 22 + i) & 31]));
    lp_wp  = (p + 1) & 31;
    lp_out = 16'(acc_z >>> 15);

    prior   = lp_prev;
    lp_prev = lp_out;
    if (lp_out > swing_hi) swing_hi = lp_out;
    if (lp_out < swing_lo) swing_lo = lp_out;

    r = '0;
    if (prior < 0 && lp_out >= 0) begin
      // rising zero crossing: extrema restart whether or not it is gated
      swing    = int'(swing_hi) - int'(swing_lo);
      swing_hi = 16'sh8000;
      swing_lo = 16'sh7FFF;
      if (swing > int'(gate_amp_floor) && swing < int'(gate_amp_ceiling)) begin
        gap_ms  = ms - beat_ms;
        r.beat  = 1'b1;
        beat_ms = ms;                     // taken even when the interval fails
        if (gap_ms > 32'(gate_int_min) && gap_ms < 32'(gate_int_max)) begin
          bpm = 60000 / gap_ms;
          if (bpm > 255) bpm = 255;
          bpm_ring[ring_wp] = 8'(bpm);
          ring_wp  = (ring_wp + 1) % HIST_DEPTH;
          ring_sum = 0;
          for (i = 0; i < HIST_DEPTH; i++) ring_sum += bpm_ring[i];
          bpm_avg    = 8'(ring_sum / HIST_DEPTH);
          r.rate_acc = 1'b1;
        end
      end
    end
    r.avg  = bpm_avg;
    r.filt = lp_out;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input channel: offers one sample, idling at random first
  // ---------------------------------------------------------------------------
  task automatic drive_sample(input logic [17:0] ir, input logic [31:0] ms,
                              input logic fixed_valid, input reading_t fixed);
    reading_t guess;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.ir_sample <= ir;
    in_bus.now_ms    <= ms;
    do @(posedge clk); while (!in_bus.ready);
    guess = predict_reading(ir, ms);
    awaited_readings.push_back(fixed_valid ? fixed : guess);
  endtask

  // Sender stops and waits for every outstanding reading
  task automatic hold_until_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (awaited_readings.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; lands when pready is seen
  task automatic write_gate(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom()), value};   // upper half must be ignored
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_AMP_FLOOR:   gate_amp_floor   = value;
      REG_AMP_CEILING: gate_amp_ceiling = value;
      REG_INT_MIN:     gate_int_min     = value;
      REG_INT_MAX:     gate_int_max     = value;
      default: ;
    endcase
  endtask

  task automatic set_gates(input logic [15:0] amp_lo, input logic [15:0] amp_hi,
                           input logic [15:0] gap_lo, input logic [15:0] gap_hi);
    write_gate(REG_AMP_FLOOR, amp_lo);
    write_gate(REG_AMP_CEILING, amp_hi);
    write_gate(REG_INT_MIN, gap_lo);
    write_gate(REG_INT_MAX, gap_hi);
  endtask

  // Triangle pulse wave on a random baseline: one zero crossing per period,
  // interval about period * step; sometimes cut short mid-period
  task automatic send_pulse_train();
    int          period;
    int          amp;
    int          level;
    int          step_ms;
    int          count;
    int          n;
    int          k;
    int          tri_val;
    logic [17:0] ir;
    period  = 2 * $urandom_range(12, 32);
    amp     = $urandom_range(60, 2600);
    level   = $urandom_range(amp + 16, 65519 - amp);
    step_ms = $urandom_range(4, 60);
    count   = $urandom_range(2, 5) * period - $urandom_range(0, period / 2);
    for (n = 0; n < count && items_sent < items_quota; n++) begin
      k       = n % period;
      tri_val = (k < period / 2) ? -amp + (4 * amp * k) / period
                                 : 3 * amp - (4 * amp * k) / period;
      ir[15:0]  = 16'(level + tri_val + int'($urandom_range(0, 16)) - 8);
      ir[17:16] = 2'($urandom_range(3));
      stream_ms = stream_ms + step_ms + $urandom_range(0, 2);
      drive_sample(ir, stream_ms, 1'b0, NO_READING);
      items_sent++;
    end
  endtask

  // Short burst of junk: random, full-scale or zero samples, random timestamps
  task automatic send_noise();
    int          len;
    int          n;
    logic [17:0] ir;
    len = $urandom_range(1, 8);
    for (n = 0; n < len && items_sent < items_quota; n++) begin
      if ($urandom_range(3) == 0) ir = $urandom_range(1) ? 18'h3FFFF : 18'h00000;
      else ir = 18'($urandom());
      drive_sample(ir, $urandom(), 1'b0, NO_READING);
      items_sent++;
    end
  endtask

  task automatic run_phase(input int items, input int src_pct, input int snk_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = snk_pct;
    items_quota   = items_sent + items;
    // half the phases start just short of the 32-bit wrap of the ms counter
    if ($urandom_range(1)) stream_ms = $urandom();
    else stream_ms = 32'hFFFF_FF00 - $urandom_range(0, 4000);
    while (items_sent < items_quota) begin
      if ($urandom_range(99) < 80) send_pulse_train();
      else send_noise();
      if ($urandom_range(39) == 0) hold_until_drained();
    end
    hold_until_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Typed rows: clean state after reset, zero and full-scale
  // samples. The rest (bit patterns, a square burst) go through the predictor.
  // ---------------------------------------------------------------------------
  probe_row_t probe_rows [24] = '{
    '{18'h00000, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 8'd0, 16'sd0}},
    // only the dropped top bits set: still a zero sample
    '{18'h30000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 8'd0, 16'sd0}},
    // full scale: AC part -4096 meets the outer tap only
    '{18'h3FFFF, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 8'd0, -16'sd22}},
    '{18'h0FFFF, 32'h8000_0000, 1'b0, NO_READING},
    '{18'h10000, 32'h0000_0001, 1'b0, NO_READING},
    '{18'h20000, 32'h7FFF_FFFF, 1'b0, NO_READING},
    '{18'h2AAAA, 32'hAAAA_AAAA, 1'b0, NO_READING},
    '{18'h15555, 32'h5555_5555, 1'b0, NO_READING},
    // square burst, steps of 100 ms, to drive crossings through the gates
    '{18'h01800, 32'd1000, 1'b0, NO_READING},
    '{18'h01800, 32'd1100, 1'b0, NO_READING},
    '{18'h11800, 32'd1200, 1'b0, NO_READING},
    '{18'h01800, 32'd1300, 1'b0, NO_READING},
    '{18'h02800, 32'd1400, 1'b0, NO_READING},
    '{18'h02800, 32'd1500, 1'b0, NO_READING},
    '{18'h22800, 32'd1600, 1'b0, NO_READING},
    '{18'h02800, 32'd1700, 1'b0, NO_READING},
    '{18'h01800, 32'd1800, 1'b0, NO_READING},
    '{18'h31800, 32'd1900, 1'b0, NO_READING},
    '{18'h01800, 32'd2000, 1'b0, NO_READING},
    '{18'h01800, 32'd2100, 1'b0, NO_READING},
    '{18'h02800, 32'd2200, 1'b0, NO_READING},
    '{18'h02800, 32'd2300, 1'b0, NO_READING},
    '{18'h12800, 32'd2400, 1'b0, NO_READING},
    '{18'h02800, 32'd2500, 1'b0, NO_READING}
  };

  // ---------------------------------------------------------------------------
  // Result channel: random back-pressure, driven on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) out_bus.ready <= ($urandom_range(99) >= sink_idle_pct);

  // Scoreboard and watchdog, both on the rising edge
  reading_t want;
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (awaited_readings.size() == 0) begin
        $error("result beat with no reading outstanding");
        mismatch_count++;
      end else begin
        want = awaited_readings.pop_front();
        if (out_bus.beat !== want.beat) begin
          $error("beat: expected %0d, got %0d", want.beat, out_bus.beat);
          mismatch_count++;
        end
        if (out_bus.rate_accepted !== want.rate_acc) begin
          $error("rate_accepted: expected %0d, got %0d", want.rate_acc,
                 out_bus.rate_accepted);
          mismatch_count++;
        end
        if (out_bus.beat_average !== want.avg) begin
          $error("beat_average: expected %0d, got %0d", want.avg, out_bus.beat_average);
          mismatch_count++;
        end
        if (out_bus.filtered_value !== want.filt) begin
          $error("filtered_value: expected %0d, got %0d", want.filt,
                 out_bus.filtered_value);
          mismatch_count++;
        end
      end
    end
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("pulse_beat_detector_unit_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int row_idx;
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.ir_sample = '0;
    in_bus.now_ms    = '0;
    out_bus.ready    = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    clear_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows under the reset gates; sender idles lightly, receiver heavily
    for (row_idx = 0; row_idx < 24; row_idx++)
      drive_sample(probe_rows[row_idx].ir, probe_rows[row_idx].ms,
                   probe_rows[row_idx].typed, probe_rows[row_idx].res);
    hold_until_drained();
    run_phase(200, 26, 83);

    // gates wide open: noise beats too, bpm saturates at 255 for short gaps
    set_gates(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    run_phase(220, 83, 26);

    // gates shut: no heartbeat can pass
    set_gates(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    run_phase(60, 0, 0);

    // ordinary gates, full throughput
    set_gates(16'd40, 16'd12000, 16'd250, 16'd2500);
    run_phase(220, 0, 0);

    // all readings are in; let anything stray show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_readings.size() == 0)
      $display("pulse_beat_detector_unit_tb: PASS");
    else
      $display("pulse_beat_detector_unit_tb: FAIL");
    $finish;
  end

endmodule

// ===== pulse_beat_detector_unit.f =====
hw/rtl/pbd_pkg.sv
hw/rtl/pbd_if.sv
hw/rtl/pbd_regs.sv
hw/rtl/pbd_line.sv
hw/rtl/pbd_div.sv
hw/rtl/pulse_beat_detector_unit.sv
tb/pulse_beat_detector_unit_tb.sv
